// ----- rtl/rlkd_pkg.sv -----
// Shared types and constants for the resistor-ladder key decoder.
// No dependencies; every other file imports this package.
package rlkd_pkg;

   localparam int SAMPLE_W    = 10;
   localparam int MASK_W      = 3;
   localparam int LEVEL_COUNT = 7;
   localparam int CSR_IDX_W   = 3;
   localparam int DIST_W      = SAMPLE_W + 1;

   // register index of the tolerance; indexes below it select a level
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 3'd7;

   localparam logic [SAMPLE_W-1:0] TOLERANCE_RESET = 10'd4;
   localparam logic [DIST_W-1:0]   NO_DISTANCE     = 11'd1024;

   typedef struct packed {
      logic [LEVEL_COUNT-1:0][SAMPLE_W-1:0] level;
      logic [SAMPLE_W-1:0]                  tolerance;
   } csr_regs_type;

   typedef struct packed {
      logic [MASK_W-1:0] pattern;  // matched pattern, zero for a released line
      logic              hit;      // zero sample or within tolerance
   } match_res_type;

endpackage

// ----- rtl/rlkd_csr.sv -----
// Configuration register file: seven ladder levels and the match tolerance.
// Depends on rlkd_pkg.
module rlkd_csr
   import rlkd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SAMPLE_W-1:0]  csr_wdata,
   output csr_regs_type         regs
);

   csr_regs_type regs_ff;
   csr_regs_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TOLERANCE: regs_in.tolerance = csr_wdata;
            default:       regs_in.level[csr_index] = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.level     <= '0;
         regs_ff.tolerance <= TOLERANCE_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

// ----- rtl/rlkd_match.sv -----
// Nearest-level search: distance to each active level, lowest index wins ties.
// Depends on rlkd_pkg.
module rlkd_match
   import rlkd_pkg::*;
#(
   parameter int NUM_BUTTONS = 3
)
(
   input  logic [SAMPLE_W-1:0] sample,
   input  csr_regs_type        regs,
   output match_res_type       res
);

   localparam int USED_LEVELS = (1 << NUM_BUTTONS) - 1;
   localparam logic [MASK_W-1:0] BUTTON_MASK = MASK_W'((1 << NUM_BUTTONS) - 1);

   always_comb begin
      logic [DIST_W-1:0]   best;
      logic [MASK_W-1:0]   best_idx;
      logic [SAMPLE_W-1:0] lv;
      logic [SAMPLE_W-1:0] diff;
      best     = NO_DISTANCE;
      best_idx = '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         lv   = regs.level[i];
         diff = (lv >= sample) ? (lv - sample) : (sample - lv);
         // strict compare keeps the lower index on a tie
         if ((i < USED_LEVELS) && ({1'b0, diff} < best)) begin
            best     = {1'b0, diff};
            best_idx = MASK_W'(i);
         end
      end
      if (sample == '0) begin
         res.pattern = '0;
         res.hit     = 1'b1;
      end else if (best > {1'b0, regs.tolerance}) begin
         res.pattern = '0;
         res.hit     = 1'b0;
      end else begin
         res.pattern = (best_idx + MASK_W'(1)) & BUTTON_MASK;
         res.hit     = 1'b1;
      end
   end

endmodule

// ----- rtl/resistor_ladder_key_decoder.sv -----
// Resistor-ladder key decoder: one ADC sample in, one result beat out per cycle
// while rsp_ready is high. A sample beat is registered, matched against the
// levels and latched into the result register when that register is empty or
// being drained; the nearest-level compare between the two registers sets the
// clock limit. A zero sample means released; a sample farther than the tolerance
// from every active level holds the previous pattern and clears level_matched.
// Levels and tolerance are to be written through the csr port only while idle;
// the block does not enforce it. Depends on rlkd_pkg, rlkd_csr and rlkd_match.
module resistor_ladder_key_decoder
   import rlkd_pkg::*;
#(
   parameter int NUM_BUTTONS = 3
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [SAMPLE_W-1:0]  req_adc_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [MASK_W-1:0]    rsp_pressed_mask,
   output logic [MASK_W-1:0]    rsp_down_mask,
   output logic [MASK_W-1:0]    rsp_up_mask,
   output logic                 rsp_level_matched,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SAMPLE_W-1:0]  csr_wdata
);

   csr_regs_type  regs;
   match_res_type res;

   logic                samp_valid_ff, samp_valid_in;
   logic [SAMPLE_W-1:0] samp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]   last_pressed_ff, last_pressed_in;
   logic [MASK_W-1:0]   pressed_ff, down_ff, up_ff;
   logic                matched_ff;
   logic [MASK_W-1:0]   now_mask;
   logic                advance;
   logic                accept;

   rlkd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   rlkd_match #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_match (
      .sample (samp_ff),
      .regs   (regs),
      .res    (res)
   );

   // sample beat moves on whenever the result register is empty or being drained
   assign advance   = samp_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !samp_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign now_mask        = res.hit ? res.pattern : last_pressed_ff;
   assign samp_valid_in   = accept || (samp_valid_ff && !advance);
   assign rsp_valid_in    = advance || (rsp_valid_ff && !rsp_ready);
   assign last_pressed_in = advance ? now_mask : last_pressed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         samp_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         last_pressed_ff <= '0;
      end else begin
         samp_valid_ff   <= samp_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         last_pressed_ff <= last_pressed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         samp_ff <= req_adc_sample;
      end
      if (advance) begin
         pressed_ff <= now_mask;
         down_ff    <= now_mask & ~last_pressed_ff;
         up_ff      <= ~now_mask & last_pressed_ff;
         matched_ff <= res.hit;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pressed_mask  = pressed_ff;
   assign rsp_down_mask     = down_ff;
   assign rsp_up_mask       = up_ff;
   assign rsp_level_matched = matched_ff;

`ifndef SYNTH
   a_state_tracks_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> (last_pressed_ff == rsp_pressed_mask))
      else $error("held pattern differs from the last result beat");

   a_down_up_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_down_mask & rsp_up_mask) == '0))
      else $error("button both pressed and released in one beat");

   a_down_is_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_down_mask & ~rsp_pressed_mask) == '0))
      else $error("down mask bit set for a button not pressed");

   a_miss_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_level_matched) |-> (rsp_down_mask == '0 && rsp_up_mask == '0))
      else $error("unmatched sample changed the pattern");
`endif

endmodule

// ----- tb/tb_resistor_ladder_key_decoder.sv -----
// Self-checking testbench for the resistor-ladder key decoder.
// Needs rlkd_pkg and resistor_ladder_key_decoder; predicts every result beat in place.
`timescale 1ns / 1ps
module tb_resistor_ladder_key_decoder
   import rlkd_pkg::*;
();

   localparam int NUM_BUTTONS    = 3;
   localparam int USED_LEVELS    = (1 << NUM_BUTTONS) - 1;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [MASK_W-1:0] pressed;
      logic [MASK_W-1:0] down;
      logic [MASK_W-1:0] up;
      logic              matched;
   } key_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [SAMPLE_W-1:0]  req_adc_sample;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [MASK_W-1:0]    rsp_pressed_mask;
   logic [MASK_W-1:0]    rsp_down_mask;
   logic [MASK_W-1:0]    rsp_up_mask;
   logic                 rsp_level_matched;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SAMPLE_W-1:0]  csr_wdata;

   // predictor state
   csr_regs_type         csr_shadow;
   logic [MASK_W-1:0]    held_pattern;
   key_result_type       expected_keys[$];

   int                   fault_count;
   int                   cycle_count;
   int                   send_idle_pct;
   int                   rsp_idle_pct;
   logic                 holdoff_pending;

   resistor_ladder_key_decoder #(
      .NUM_BUTTONS(NUM_BUTTONS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_adc_sample   (req_adc_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pressed_mask (rsp_pressed_mask),
      .rsp_down_mask    (rsp_down_mask),
      .rsp_up_mask      (rsp_up_mask),
      .rsp_level_matched(rsp_level_matched),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // nearest active level, lowest index on a tie; out of tolerance holds the pattern
   function automatic key_result_type predict_keys(input logic [SAMPLE_W-1:0] sample);
      key_result_type    r;
      logic [DIST_W-1:0] nearest;
      logic [DIST_W-1:0] gap;
      logic [SAMPLE_W-1:0] lv;
      logic [MASK_W-1:0] pattern;
      int                winner;
      int                i;
      pattern   = held_pattern;
      r.matched = 1'b1;
      if (sample == '0) begin
         pattern = '0;
      end else begin
         nearest = NO_DISTANCE;
         winner  = 0;
         for (i = 0; i < USED_LEVELS; i++) begin
            lv  = csr_shadow.level[i];
            gap = (lv >= sample) ? DIST_W'(lv - sample) : DIST_W'(sample - lv);
            if (gap < nearest) begin
               nearest = gap;
               winner  = i;
            end
         end
         if (nearest > DIST_W'(csr_shadow.tolerance)) begin
            r.matched = 1'b0;
         end else begin
            pattern = MASK_W'(winner + 1) & MASK_W'((1 << NUM_BUTTONS) - 1);
         end
      end
      r.pressed = pattern;
      r.down    = pattern & ~held_pattern;
      r.up      = ~pattern & held_pattern;
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] clamp_code(input int v);
      if (v < 0)
         return '0;
      if (v > 1023)
         return '1;
      return SAMPLE_W'(v);
   endfunction

   function automatic csr_regs_type random_levels();
      csr_regs_type regs;
      int           style;
      int           base;
      int           i;
      style = $urandom_range(3);
      base  = $urandom_range(1023);
      for (i = 0; i < LEVEL_COUNT; i++) begin
         case (style)
            2: begin
               // tight cluster, plenty of ties and near misses
               regs.level[i] = clamp_code(base + int'($urandom_range(24)) - 12);
            end
            3: begin
               regs.level[i] = clamp_code((i + 1) * int'($urandom_range(40, 146)));
            end
            default: begin
               regs.level[i] = SAMPLE_W'($urandom);
            end
         endcase
         if ($urandom_range(15) == 0)
            regs.level[i] = $urandom_range(1) ? '1 : '0;
      end
      case ($urandom_range(7))
         0:       regs.tolerance = '0;
         1:       regs.tolerance = '1;
         2:       regs.tolerance = SAMPLE_W'($urandom);
         default: regs.tolerance = SAMPLE_W'($urandom_range(24));
      endcase
      return regs;
   endfunction

   // sample near an active level, straddling the tolerance edge when the tolerance is below 23
   function automatic logic [SAMPLE_W-1:0] near_level(input int idx);
      int span;
      span = (csr_shadow.tolerance > 22) ? 24 : int'(csr_shadow.tolerance) + 2;
      return clamp_code(int'(csr_shadow.level[idx]) + int'($urandom_range(2 * span)) - span);
   endfunction

   task automatic offer_sample(input logic [SAMPLE_W-1:0] sample);
      key_result_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid      = 1'b0;
         req_adc_sample = SAMPLE_W'($urandom);
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_adc_sample = sample;
      do
         @(posedge clock);
      while (!req_ready);
      want         = predict_keys(sample);
      held_pattern = want.pressed;
      expected_keys.push_back(want);
      @(negedge clock);
   endtask

   task automatic settle_pipeline();
      req_valid = 1'b0;
      while (expected_keys.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_csr(input csr_regs_type regs);
      int i;
      settle_pipeline();
      for (i = 0; i < LEVEL_COUNT; i++) begin
         csr_wr_en = 1'b1;
         csr_index = CSR_IDX_W'(i);
         csr_wdata = regs.level[i];
         @(negedge clock);
      end
      csr_index = CSR_TOLERANCE;
      csr_wdata = regs.tolerance;
      @(negedge clock);
      csr_wr_en  = 1'b0;
      csr_shadow = regs;
   endtask

   // reset levels are all zero with tolerance four
   task automatic test_reset_state();
      offer_sample(10'd0);
      offer_sample(10'd4);
      offer_sample(10'd5);
      offer_sample(10'd0);
   endtask

   task automatic test_every_pattern();
      csr_regs_type regs;
      int           i;
      for (i = 0; i < LEVEL_COUNT; i++)
         regs.level[i] = SAMPLE_W'((i + 1) * 100);
      regs.tolerance = 10'd10;
      program_csr(regs);
      for (i = 0; i < LEVEL_COUNT; i++)
         offer_sample(regs.level[i]);
      offer_sample(10'd711);   // just outside: held, unmatched
      offer_sample(10'd710);   // on the tolerance edge
      offer_sample(10'd0);
      offer_sample(10'd1023);  // far from all: held, unmatched
   endtask

   task automatic test_ties_and_extremes();
      csr_regs_type regs;
      regs.level[0]  = 10'd10;
      regs.level[1]  = 10'd30;
      regs.level[2]  = 10'd30;
      regs.level[3]  = 10'd1023;
      regs.level[4]  = 10'd0;
      regs.level[5]  = 10'd500;
      regs.level[6]  = 10'd500;
      regs.tolerance = 10'd1023;
      program_csr(regs);
      offer_sample(10'd20);    // equidistant from first two levels
      offer_sample(10'd30);    // duplicate level, lower index wins
      offer_sample(10'd500);
      offer_sample(10'd1023);
      offer_sample(10'd1);
      regs.tolerance = 10'd0;
      program_csr(regs);
      offer_sample(10'd1022);
      offer_sample(10'd1023);
      offer_sample(10'd501);
   endtask

   task automatic run_key_traffic(input int send_pct, input int rsp_pct);
      int block;
      int sent;
      int run;
      int k;
      int idx;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      for (block = 0; block < 4; block++) begin
         program_csr(random_levels());
         sent = 0;
         while (sent < 100) begin
            if ($urandom_range(4) == 0) begin
               offer_sample(SAMPLE_W'($urandom));
               sent++;
            end else begin
               // keystroke: a few jittery samples on one level, often a release
               idx = $urandom_range(USED_LEVELS - 1);
               run = $urandom_range(1, 4);
               for (k = 0; k < run; k++) begin
                  offer_sample(near_level(idx));
                  sent++;
               end
               if ($urandom_range(2) != 0) begin
                  offer_sample('0);
                  sent++;
               end
            end
         end
      end
      settle_pipeline();
   endtask

   // long receiver hold-off while samples keep coming, so the input stalls
   task automatic test_backpressure();
      int i;
      send_idle_pct   = 0;
      holdoff_pending = 1'b1;
      for (i = 0; i < 40; i++)
         offer_sample(near_level($urandom_range(USED_LEVELS - 1)));
      settle_pipeline();
   endtask

   initial begin : rsp_pacer
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_pending) begin
            rsp_ready = 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
            holdoff_pending = 1'b0;
         end
         rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : result_check
      key_result_type got;
      key_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_pressed_mask, rsp_down_mask, rsp_up_mask, rsp_level_matched};
         if (expected_keys.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected result beat: pressed %0h down %0h up %0h matched %0b",
                        got.pressed, got.down, got.up, got.matched);
         end else begin
            want = expected_keys.pop_front();
            if (got !== want) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display({"mismatch (exp/got): pressed %0h/%0h down %0h/%0h",
                            " up %0h/%0h matched %0b/%0b"},
                           want.pressed, got.pressed, want.down, got.down,
                           want.up, got.up, want.matched, got.matched);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("resistor_ladder_key_decoder verification failed");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_adc_sample   = '0;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      fault_count      = 0;
      cycle_count      = 0;
      send_idle_pct    = 0;
      rsp_idle_pct     = 0;
      holdoff_pending  = 1'b0;
      held_pattern     = '0;
      csr_shadow.level = '0;
      csr_shadow.tolerance = TOLERANCE_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_every_pattern();
      test_ties_and_extremes();
      run_key_traffic(18, 72);
      test_backpressure();
      run_key_traffic(72, 18);
      run_key_traffic(0, 0);

      settle_pipeline();
      if (fault_count == 0)
         $display("resistor_ladder_key_decoder verification clean");
      else
         $display("resistor_ladder_key_decoder verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/rlkd_pkg.sv
rtl/rlkd_csr.sv
rtl/rlkd_match.sv
rtl/resistor_ladder_key_decoder.sv
tb/tb_resistor_ladder_key_decoder.sv
